FILE: rtl/smsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsl_pkg
// Shared constants, state type and key ordering for the linked-list sorter.
// ----------------------------------------------------------------------------
package smsl_pkg;
  localparam int MAX_KEYS = 32;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int LINK_W   = 6;
  localparam int KEY_W    = 32;
  localparam int DIR_W    = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_INS1,
    ST_INS2,
    ST_E_RD,
    ST_E_CAP,
    ST_E_WAIT
  } state_t;

  // true when the listed element a stays ahead of the new element b
  function automatic logic left_first(input logic [DIR_W-1:0] dir,
                                      input logic [KEY_W-1:0] ka,
                                      input logic [KEY_W-1:0] kb);
    logic r;
    case (dir)
      2'b01:        r = ($signed(ka) <= $signed(kb));
      2'b10, 2'b11: r = ($signed(ka) >= $signed(kb));
      default:      r = 1'b1;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/smsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/stable_merge_sort_link_order_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_merge_sort_link_order_core
// Stable sort of signed Q16.16 keys, threaded through a next-index link RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in      | in  | in_valid/in_ready | in_key_value, in_last_key
//  out     | out | out_valid/out_ready | out_element_index, out_element_key,
//          |     |                   | out_last_result
//  cfg     | in  | cfg_valid/cfg_ready | cfg_sort_direction
//
// Each key is linked into place on arrival by a key/link RAM read-compare loop
// over the list elements (RD, CMP), then the link updates (INS1, INS2).
// Each result takes a RAM read, a capture and a transaction, plus stalls.
// Reset clears control state; the RAMs need no clearing.
// Input is held off while results drain; out_ready low holds the result.
module stable_merge_sort_link_order_core
  import smsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] in_key_value,
  input  logic                    in_last_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [4:0]              out_element_index,
  output logic signed [KEY_W-1:0] out_element_key,
  output logic                    out_last_result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic signed [DIR_W-1:0] cfg_sort_direction
);
  state_t state_r, state_nxt;

  logic [DIR_W-1:0]  dir_r, dir_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic [IDX_W-1:0]  next_r, next_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              last_r, last_nxt;
  logic              ov_r, ov_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [KEY_W-1:0]  okey_r, okey_nxt;
  logic              olast_r, olast_nxt;

  logic              key_we;
  logic [KEY_W-1:0]  key_rd;
  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [LINK_W-1:0] link_wd;
  logic [LINK_W-1:0] link_rd;
  logic              in_acc, out_acc, ahead, done_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = ov_r && out_ready;
  assign ahead     = left_first(dir_r, key_rd, key_r);
  assign done_load = last_r || (cnt_r + CNT_W'(1) == CNT_W'(MAX_KEYS));

  assign out_valid         = ov_r;
  assign out_element_index = 5'(oidx_r);
  assign out_element_key   = okey_r;
  assign out_last_result   = olast_r;

  assign key_we  = in_acc;
  assign link_we = (state_r == ST_INS1) || (state_r == ST_INS2 && have_prev_r);
  assign link_wa = (state_r == ST_INS1) ? cnt_r[IDX_W-1:0] : prev_r;
  assign link_wd = (state_r == ST_INS1) ? LINK_W'(cur_r) : LINK_W'(cnt_r[IDX_W-1:0]);

  smsl_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_key_value),
    .raddr (cur_r),
    .rdata (key_rd)
  );

  smsl_ram #(.WIDTH(LINK_W), .DEPTH(MAX_KEYS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (cur_r),
    .rdata (link_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r == '0) state_nxt = in_last_key ? ST_E_RD : ST_IDLE;
          else state_nxt = ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_CMP;
      ST_CMP: state_nxt = (ahead && rem_r != CNT_W'(1)) ? ST_RD : ST_INS1;
      ST_INS1: state_nxt = ST_INS2;
      ST_INS2: state_nxt = done_load ? ST_E_RD : ST_IDLE;
      ST_E_RD: state_nxt = ST_E_CAP;
      ST_E_CAP: state_nxt = ST_E_WAIT;
      ST_E_WAIT: begin
        if (out_acc) state_nxt = olast_r ? ST_IDLE : ST_E_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dir_nxt       = cfg_valid ? cfg_sort_direction : dir_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    ecnt_nxt      = ecnt_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    have_prev_nxt = have_prev_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    ov_nxt        = ov_r;
    oidx_nxt      = oidx_r;
    okey_nxt      = okey_r;
    olast_nxt     = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt       = in_key_value;
          last_nxt      = in_last_key;
          have_prev_nxt = 1'b0;
          rem_nxt       = cnt_r;
          if (cnt_r == '0) begin
            head_nxt = '0;
            cnt_nxt  = CNT_W'(1);
            cur_nxt  = '0;
            ecnt_nxt = '0;
          end else begin
            cur_nxt = head_r;
          end
        end
      end
      ST_CMP: begin
        if (ahead) begin
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          rem_nxt       = rem_r - CNT_W'(1);
          cur_nxt       = link_rd[IDX_W-1:0];
        end
      end
      ST_INS2: begin
        if (!have_prev_r) head_nxt = cnt_r[IDX_W-1:0];
        cnt_nxt  = cnt_r + CNT_W'(1);
        cur_nxt  = have_prev_r ? head_r : cnt_r[IDX_W-1:0];
        ecnt_nxt = '0;
      end
      ST_E_CAP: begin
        ov_nxt    = 1'b1;
        oidx_nxt  = cur_r;
        okey_nxt  = key_rd;
        olast_nxt = (ecnt_r + CNT_W'(1) == cnt_r);
        next_nxt  = link_rd[IDX_W-1:0];
      end
      ST_E_WAIT: begin
        if (out_acc) begin
          ov_nxt   = 1'b0;
          cur_nxt  = next_r;
          ecnt_nxt = ecnt_r + CNT_W'(1);
          if (olast_r) cnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dir_r       <= DIR_W'(1);
      cnt_r       <= '0;
      head_r      <= '0;
      ov_r        <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      ov_r        <= ov_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    ecnt_r  <= ecnt_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    next_r  <= next_nxt;
    key_r   <= key_nxt;
    last_r  <= last_nxt;
    oidx_r  <= oidx_nxt;
    okey_r  <= okey_nxt;
    olast_r <= olast_nxt;
  end

`ifndef ASSERT_OFF
  a_ov_state: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == ST_E_WAIT) else $error("result valid outside drain wait");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ov_r && in_ready)) else $error("input taken while result pending");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEYS)) else $error("load count overflow");
  a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && olast_r) |=> cnt_r == '0) else $error("count not cleared after drain");
`endif
endmodule

FILE: bench/stable_merge_sort_link_order_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_merge_sort_link_order_core_tb
// Loads lists of signed keys, lets the core sort them in every direction
// setting and checks each emitted element against a stable-sort predictor,
// under random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module stable_merge_sort_link_order_core_tb;
  import smsl_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 2 * MAX_KEYS + 40;
  localparam int DIR_ASCEND  = 1;
  localparam int DIR_DESCEND = -1;
  localparam int DIR_KEEP    = 0;
  localparam int DIR_NEG_TWO = -2;

  typedef struct {
    logic [4:0]              idx;
    logic signed [KEY_W-1:0] key;
    logic                    last;
  } sorted_elem_t;

  class sort_scoreboard;
    logic signed [DIR_W-1:0] dir;
    logic signed [KEY_W-1:0] list_keys[$];
    sorted_elem_t            sorted_q[$];
    int                      errors;

    function new();
      dir    = DIR_ASCEND;
      errors = 0;
    endfunction

    function bit stays_ahead(logic signed [KEY_W-1:0] ka, logic signed [KEY_W-1:0] kb);
      if (dir == 0) return 1'b1;
      if (dir > 0) return ka <= kb;
      return ka >= kb;
    endfunction

    function void note_input(logic signed [KEY_W-1:0] k, logic last);
      int order[$];
      int pos;
      sorted_elem_t e;
      list_keys.push_back(k);
      if (!last && list_keys.size() < MAX_KEYS) return;
      for (int i = 0; i < list_keys.size(); i++) begin
        pos = order.size();
        for (int j = 0; j < order.size(); j++) begin
          if (!stays_ahead(list_keys[order[j]], list_keys[i])) begin
            pos = j;
            break;
          end
        end
        order.insert(pos, i);
      end
      foreach (order[j]) begin
        e.idx  = order[j][4:0];
        e.key  = list_keys[order[j]];
        e.last = (j == order.size() - 1);
        sorted_q.push_back(e);
      end
      list_keys.delete();
    endfunction

    function void check_result(logic [4:0] idx, logic signed [KEY_W-1:0] key, logic last);
      sorted_elem_t e;
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected element idx=%0d key=%0d last=%0b", idx, key, last);
        return;
      end
      e = sorted_q.pop_front();
      if (idx !== e.idx || key !== e.key || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp idx=%0d key=%0d last=%0b got idx=%0d key=%0d last=%0b",
                   e.idx, e.key, e.last, idx, key, last);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [KEY_W-1:0] in_key_value;
  logic                    in_last_key;
  logic                    out_valid;
  logic                    out_ready;
  logic [4:0]              out_element_index;
  logic signed [KEY_W-1:0] out_element_key;
  logic                    out_last_result;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic signed [DIR_W-1:0] cfg_sort_direction;

  sort_scoreboard sb = new();
  int tx_idle = 0;
  int rx_idle = 0;
  int stall_cnt = 0;

  stable_merge_sort_link_order_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_key_value       (in_key_value),
    .in_last_key        (in_last_key),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_element_index  (out_element_index),
    .out_element_key    (out_element_key),
    .out_last_result    (out_last_result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_sort_direction (cfg_sort_direction)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_element_index, out_element_key, out_last_result);
    out_ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_direction(int d);
    in_valid <= 1'b0;
    wait (sb.sorted_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_sort_direction <= d[DIR_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.dir = d[DIR_W-1:0];
  endtask

  task automatic send_key(logic signed [KEY_W-1:0] k, logic last);
    in_valid     <= 1'b1;
    in_key_value <= k;
    in_last_key  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, last);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return $signed($urandom_range(6)) - 3;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh00010000;
          default: return -32'sh00010000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic send_list(int len);
    for (int i = 0; i < len; i++) begin
      if (i == len - 1)
        send_key(pick_key(), (len == MAX_KEYS) ? 1'($urandom_range(1)) : 1'b1);
      else
        send_key(pick_key(), 1'b0);
    end
  endtask

  int dir_plan[6] = '{DIR_DESCEND, DIR_KEEP, DIR_NEG_TWO, DIR_ASCEND, DIR_ASCEND, DIR_DESCEND};

  initial begin
    int sent;
    int len;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_key_value       = '0;
    in_last_key        = 1'b0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_sort_direction = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_direction(DIR_ASCEND);
    send_key(32'sd5, 1'b1);
    send_key(32'sh7fffffff, 1'b0);
    send_key(32'sh80000000, 1'b0);
    send_key(32'sd0, 1'b0);
    send_key(-32'sd1, 1'b0);
    send_key(32'sh80000000, 1'b0);
    send_key(32'sh7fffffff, 1'b0);
    send_key(32'sh00010000, 1'b0);
    send_key(-32'sh00010000, 1'b1);
    write_direction(DIR_NEG_TWO);
    send_key(32'sd2, 1'b0);
    send_key(32'sh80000000, 1'b0);
    send_key(32'sd2, 1'b0);
    send_key(32'sh7fffffff, 1'b1);
    write_direction(DIR_KEEP);
    send_key(32'sd9, 1'b0);
    send_key(-32'sd9, 1'b0);
    send_key(32'sd0, 1'b1);
    write_direction(DIR_DESCEND);
    send_key(32'sd1, 1'b0);
    send_key(32'sd1, 1'b0);
    send_key(32'sd3, 1'b0);
    send_key(32'sd1, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 25 : (ph == 1) ? 73 : 0;
      rx_idle = (ph == 0) ? 73 : (ph == 1) ? 25 : 0;
      for (int s = 0; s < 2; s++) begin
        write_direction(dir_plan[ph * 2 + s]);
        sent = 0;
        while (sent < 14) begin
          len = ($urandom_range(9) == 0) ? MAX_KEYS : $urandom_range(1, 8);
          send_list(len);
          sent += len;
        end
      end
    end
    in_valid <= 1'b0;

    wait (sb.sorted_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.sorted_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
